// File: design/sflr_pkg.sv
// Shared types, constants and reset table of the serial frame register loader.
package sflr_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 255;
  localparam int HEAD_DEPTH          = 5;
  localparam int HEAD_IDX_W          = $clog2(HEAD_DEPTH);
  localparam int BANK_DEPTH          = 8;
  localparam int BANK_IDX_W          = $clog2(BANK_DEPTH);
  localparam int WRITE_FRAME_LEN     = 7;
  localparam int QUEUE_DEPTH         = 2;
  localparam int QUEUE_PTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W         = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  CH_CR      = 8'h0D;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [31:0] WORD_START = 32'h706C6179;
  localparam logic [31:0] WORD_DUMP  = 32'h64617461;

  localparam logic [31:0] BANK_INIT [BANK_DEPTH] = '{
    32'hFFFFFFFF, 32'h04600847, 32'h19DF48C4, 32'h00000000,
    32'h21D00000, 32'h00000152, 32'h6800006C, 32'h00000000
  };

  typedef enum logic [2:0] {
    EV_WRITE     = 3'd0,
    EV_START     = 3'd1,
    EV_DUMP      = 3'd2,
    EV_BAD_CMD   = 3'd3,
    EV_BAD_FRAME = 3'd4,
    EV_OVERFLOW  = 3'd5
  } event_t;

  // One classified frame, handed from the parser to the executor.
  typedef struct packed {
    event_t                  ev;
    logic [BANK_IDX_W-1:0]   idx;
    logic [31:0]             word;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic {
    BK_IDLE,
    BK_BURST
  } back_state_t;

endpackage

// File: design/sflr_front.sv
// Frame parser: accepts received bytes, tracks the frame and classifies finished frames.
module sflr_front #(
  parameter int MAX_FRAME_BYTES = sflr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  sflr_pkg::q_status_t q_status,
  output logic                push,
  output sflr_pkg::cmd_t      push_cmd
);
  import sflr_pkg::*;

  logic [7:0] byte_count;
  logic [7:0] previous_byte;
  logic [7:0] head_bytes [HEAD_DEPTH];

  logic [7:0]  head_new [HEAD_DEPTH];
  logic [7:0]  count_next;
  logic        overflow;
  logic        frame_end;
  logic        accept;
  logic [31:0] word;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign overflow = byte_count >= 8'(MAX_FRAME_BYTES);

  always_comb begin
    head_new = head_bytes;
    if (byte_count < 8'(HEAD_DEPTH)) begin
      head_new[byte_count[HEAD_IDX_W-1:0]] = rx_byte;
    end
    count_next = byte_count + 8'd1;
    frame_end  = (rx_byte == CH_LF) && (count_next >= 8'd2) && (previous_byte == CH_CR);
    word       = {head_new[1], head_new[2], head_new[3], head_new[4]};

    push_cmd = '{ev: EV_BAD_FRAME, idx: '0, word: '0};
    priority if (overflow) begin
      push_cmd.ev = EV_OVERFLOW;
    end else if (head_new[0] == CH_CR) begin
      if (word == WORD_START) begin
        push_cmd.ev = EV_START;
      end else if (word == WORD_DUMP) begin
        push_cmd.ev = EV_DUMP;
      end else begin
        push_cmd.ev   = EV_BAD_CMD;
        push_cmd.word = word;
      end
    end else if (head_new[0] < 8'(BANK_DEPTH) && count_next == 8'(WRITE_FRAME_LEN)) begin
      push_cmd.ev   = EV_WRITE;
      push_cmd.idx  = head_new[0][BANK_IDX_W-1:0];
      push_cmd.word = word;
    end else begin
      push_cmd.ev = EV_BAD_FRAME;
    end

    push = accept && (overflow || frame_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      previous_byte <= '0;
      for (int i = 0; i < HEAD_DEPTH; i++) head_bytes[i] <= '0;
    end else if (accept) begin
      if (overflow || frame_end) begin
        // drop the frame and start over
        byte_count    <= '0;
        previous_byte <= '0;
        for (int i = 0; i < HEAD_DEPTH; i++) head_bytes[i] <= '0;
      end else begin
        byte_count    <= count_next;
        previous_byte <= rx_byte;
        head_bytes    <= head_new;
      end
    end
  end

endmodule

// File: design/sflr_queue.sv
// Short command queue between the frame parser and the executor.
module sflr_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sflr_pkg::cmd_t      push_cmd,
  input  logic                pop,
  output sflr_pkg::cmd_t      pop_cmd,
  output sflr_pkg::q_status_t q_status
);
  import sflr_pkg::*;

  cmd_t                   entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] fill;

  localparam logic [QUEUE_PTR_W-1:0] PTR_LAST = QUEUE_PTR_W'(QUEUE_DEPTH - 1);

  assign q_status.full  = fill == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign q_status.empty = fill == '0;
  assign pop_cmd        = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: design/sflr_back.sv
// Executor: holds the register bank, runs writes and start/dump bursts, drives the output register.
module sflr_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sflr_pkg::q_status_t                   q_status,
  input  sflr_pkg::cmd_t                        pop_cmd,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [2:0]                            event_res,
  output logic [sflr_pkg::BANK_IDX_W-1:0]       reg_index,
  output logic [31:0]                           value,
  output logic                                  last
);
  import sflr_pkg::*;

  localparam logic [BANK_IDX_W-1:0] BANK_LAST = BANK_IDX_W'(BANK_DEPTH - 1);

  logic [31:0]           bank [BANK_DEPTH];
  back_state_t           state, state_next;
  logic [BANK_IDX_W-1:0] burst_idx, burst_idx_next;
  event_t                burst_ev, burst_ev_next;
  logic                  out_valid_next;
  event_t                out_ev, out_ev_next;
  logic [BANK_IDX_W-1:0] out_idx, out_idx_next;
  logic [31:0]           out_value, out_value_next;
  logic                  out_last, out_last_next;
  logic                  bank_we;
  logic                  can_load;
  logic [31:0]           bank_rd;

  assign can_load  = !out_valid || out_ready;
  assign bank_rd   = bank[burst_idx];
  assign event_res = out_ev;
  assign reg_index = out_idx;
  assign value     = out_value;
  assign last      = out_last;

  always_comb begin
    state_next     = state;
    burst_idx_next = burst_idx;
    burst_ev_next  = burst_ev;
    out_valid_next = out_valid;
    out_ev_next    = out_ev;
    out_idx_next   = out_idx;
    out_value_next = out_value;
    out_last_next  = out_last;
    pop            = 1'b0;
    bank_we        = 1'b0;

    unique case (state)
      BK_IDLE: begin
        if (can_load) begin
          out_valid_next = 1'b0;
          if (!q_status.empty) begin
            pop            = 1'b1;
            out_valid_next = 1'b1;
            out_ev_next    = pop_cmd.ev;
            out_idx_next   = '0;
            out_value_next = '0;
            out_last_next  = 1'b1;
            unique case (pop_cmd.ev)
              EV_WRITE: begin
                bank_we        = 1'b1;
                out_idx_next   = pop_cmd.idx;
                out_value_next = pop_cmd.word;
              end
              EV_START, EV_DUMP: begin
                // burst_idx rests at zero here: emit register 0 now
                out_value_next = bank_rd;
                out_last_next  = 1'b0;
                burst_ev_next  = pop_cmd.ev;
                burst_idx_next = burst_idx + 1'b1;
                state_next     = BK_BURST;
              end
              EV_BAD_CMD: out_value_next = pop_cmd.word;
              default: ;
            endcase
          end
        end
      end
      BK_BURST: begin
        if (can_load) begin
          out_valid_next = 1'b1;
          out_ev_next    = burst_ev;
          out_idx_next   = burst_idx;
          out_value_next = bank_rd;
          out_last_next  = burst_idx == BANK_LAST;
          burst_idx_next = burst_idx + 1'b1;
          if (burst_idx == BANK_LAST) state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      burst_idx <= '0;
      burst_ev  <= EV_START;
      out_valid <= 1'b0;
      for (int i = 0; i < BANK_DEPTH; i++) bank[i] <= BANK_INIT[i];
    end else begin
      state     <= state_next;
      burst_idx <= burst_idx_next;
      burst_ev  <= burst_ev_next;
      out_valid <= out_valid_next;
      if (bank_we) bank[pop_cmd.idx] <= pop_cmd.word;
    end
  end

  always_ff @(posedge clk) begin
    out_ev    <= out_ev_next;
    out_idx   <= out_idx_next;
    out_value <= out_value_next;
    out_last  <= out_last_next;
  end

endmodule

// File: design/serial_frame_register_loader_unit.sv
// Top level of the serial frame register loader: parser, command queue and executor.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   in      | in_valid, in_ready, rx_byte               | input
//   out     | out_valid, out_ready, event_res,          | output
//           | reg_index, value, last                    |
//
// A byte is taken in the cycle it arrives while the two-entry command queue has room.
// The first result of a finished frame passes through the command queue and the output
// register; a start or dump frame yields eight results, one bank register per cycle while
// the output is not stalled, from the executor's single read port.
// Synchronous reset clears the frame, the queue and the output, and reloads the bank.
// A stalled output holds the executor; the parser keeps taking bytes until the queue fills.
module serial_frame_register_loader_unit #(
  parameter int MAX_FRAME_BYTES = sflr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      event_res,
  output logic [sflr_pkg::BANK_IDX_W-1:0] reg_index,
  output logic [31:0]                     value,
  output logic                            last
);
  import sflr_pkg::*;

  q_status_t q_status;
  logic      push;
  logic      pop;
  cmd_t      push_cmd;
  cmd_t      pop_cmd;

  sflr_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .q_status (q_status),
    .push     (push),
    .push_cmd (push_cmd)
  );

  sflr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_status (q_status)
  );

  sflr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_status  (q_status),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .reg_index (reg_index),
    .value     (value),
    .last      (last)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("command popped from an empty queue");

  a_burst_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_START || event_res == EV_DUMP) |->
      (last == (reg_index == BANK_IDX_W'(BANK_DEPTH - 1))))
    else $error("last flag out of place in a start or dump burst");

  a_error_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EV_BAD_CMD || event_res == EV_BAD_FRAME ||
                  event_res == EV_OVERFLOW) |-> (reg_index == '0) && last)
    else $error("error transaction with nonzero index or without last");

endmodule

// File: tb/sv/tb_serial_frame_register_loader_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the serial frame register loader unit.
module tb_serial_frame_register_loader_unit;
  import sflr_pkg::*;

  localparam int FRAME_LIMIT  = MAX_FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASE_BYTES  = 50;

  typedef struct packed {
    event_t                ev;
    logic [BANK_IDX_W-1:0] idx;
    logic [31:0]           val;
    logic                  last;
  } loader_result_t;

  typedef enum int {
    FK_WRITE,
    FK_START,
    FK_DUMP,
    FK_BAD_CMD,
    FK_BAD_LEN,
    FK_BAD_FRAME,
    FK_NOISE
  } frame_kind_t;

  // Tracks frame parsing and the register bank, and holds the results each byte should cause.
  class frame_scoreboard;
    logic [7:0]     frame_len;
    logic [7:0]     head [HEAD_DEPTH];
    logic [7:0]     prior_byte;
    logic [31:0]    bank [BANK_DEPTH];
    loader_result_t results_due [$];
    int             errors;

    function new();
      errors = 0;
      clear_frame();
      foreach (bank[i]) bank[i] = BANK_INIT[i];
    endfunction

    function void clear_frame();
      frame_len  = '0;
      prior_byte = '0;
      foreach (head[i]) head[i] = '0;
    endfunction

    function void push_result(event_t ev, int idx, logic [31:0] val, logic last);
      loader_result_t r;
      r.ev   = ev;
      r.idx  = idx[BANK_IDX_W-1:0];
      r.val  = val;
      r.last = last;
      results_due.push_back(r);
    endfunction

    function void note_byte(logic [7:0] b);
      logic [31:0] word;
      event_t      ev;
      // drop the byte once the frame is full
      if (frame_len >= FRAME_LIMIT) begin
        clear_frame();
        push_result(EV_OVERFLOW, 0, '0, 1'b1);
        return;
      end
      if (frame_len < HEAD_DEPTH) head[frame_len] = b;
      frame_len = frame_len + 8'd1;
      if (!(b == CH_LF && frame_len >= 2 && prior_byte == CH_CR)) begin
        prior_byte = b;
        return;
      end
      word = {head[1], head[2], head[3], head[4]};
      if (head[0] == CH_CR) begin
        if (word == WORD_START || word == WORD_DUMP) begin
          ev = (word == WORD_START) ? EV_START : EV_DUMP;
          for (int i = 0; i < BANK_DEPTH; i++)
            push_result(ev, i, bank[i], i == BANK_DEPTH - 1);
        end else begin
          push_result(EV_BAD_CMD, 0, word, 1'b1);
        end
      end else if (head[0] < BANK_DEPTH && frame_len == WRITE_FRAME_LEN) begin
        bank[head[0][BANK_IDX_W-1:0]] = word;
        push_result(EV_WRITE, int'(head[0]), word, 1'b1);
      end else begin
        push_result(EV_BAD_FRAME, 0, '0, 1'b1);
      end
      clear_frame();
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_result(logic [2:0] ev, logic [BANK_IDX_W-1:0] idx,
                      logic [31:0] val, logic last);
      loader_result_t want;
      if (results_due.size() == 0) begin
        report($sformatf("unexpected transaction: event %0d index %0d value %h last %b",
                         ev, idx, val, last));
        return;
      end
      want = results_due.pop_front();
      if (ev !== want.ev)
        report($sformatf("event_res %0d, want %0d", ev, want.ev));
      if (idx !== want.idx)
        report($sformatf("reg_index %0d, want %0d", idx, want.idx));
      if (val !== want.val)
        report($sformatf("value %h, want %h", val, want.val));
      if (last !== want.last)
        report($sformatf("last %b, want %b", last, want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic [2:0]            event_res;
  logic [BANK_IDX_W-1:0] reg_index;
  logic [31:0]           value;
  logic                  last;

  frame_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int sent_bytes     = 0;
  int cycle_count    = 0;

  serial_frame_register_loader_unit #(
    .MAX_FRAME_BYTES(FRAME_LIMIT)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .event_res (event_res),
    .reg_index (reg_index),
    .value     (value),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check each result transaction and stall the output at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(event_res, reg_index, value, last);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b);
    sent_bytes++;
  endtask

  task automatic send_random_bytes(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic send_word(input logic [31:0] word);
    for (int i = 3; i >= 0; i--) send_byte(word[i*8 +: 8]);
  endtask

  task automatic end_frame();
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Hold the input until every pending result has come out.
  task automatic wait_results_out();
    in_valid <= 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
  endtask

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 30) return FK_WRITE;
    if (r < 40) return FK_START;
    if (r < 50) return FK_DUMP;
    if (r < 60) return FK_BAD_CMD;
    if (r < 70) return FK_BAD_LEN;
    if (r < 80) return FK_BAD_FRAME;
    return FK_NOISE;
  endfunction

  task automatic send_frame(input frame_kind_t kind);
    int n;
    unique case (kind)
      FK_WRITE: begin
        send_byte(8'($urandom_range(0, BANK_DEPTH - 1)));
        send_word($urandom());
        end_frame();
      end
      FK_START: begin
        send_byte(CH_CR);
        send_word(WORD_START);
        end_frame();
      end
      FK_DUMP: begin
        send_byte(CH_CR);
        send_word(WORD_DUMP);
        end_frame();
      end
      FK_BAD_CMD: begin
        send_byte(CH_CR);
        send_random_bytes($urandom_range(0, 5));
        end_frame();
      end
      FK_BAD_LEN: begin
        // any payload length except the four bytes of a register write
        n = $urandom_range(0, 5);
        if (n >= 4) n++;
        send_byte(8'($urandom_range(0, BANK_DEPTH - 1)));
        send_random_bytes(n);
        end_frame();
      end
      FK_BAD_FRAME: begin
        send_byte(8'($urandom_range(BANK_DEPTH, 255)));
        send_random_bytes($urandom_range(0, 6));
        end_frame();
      end
      default: send_random_bytes($urandom_range(1, 4));
    endcase
  endtask

  // Fill the frame past its limit; the closing CR LF lands around the boundary.
  task automatic send_overflow_run();
    logic [7:0] b;
    repeat ($urandom_range(FRAME_LIMIT - 1, FRAME_LIMIT + 3)) begin
      do b = 8'($urandom_range(0, 255)); while (b == CH_LF);
      send_byte(b);
    end
    end_frame();
  endtask

  initial begin
    logic [7:0] directed [$];
    int phase_start;
    sb = new();
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    rx_byte   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // lone LF, write of the top register, start, dump, shortest command frame
    directed = '{CH_LF, CH_CR, CH_LF,
                 8'(BANK_DEPTH - 1), 8'hFF, 8'h00, 8'hFF, 8'h00, CH_CR, CH_LF,
                 CH_CR, WORD_START[31:24], WORD_START[23:16], WORD_START[15:8],
                 WORD_START[7:0], CH_CR, CH_LF,
                 CH_CR, WORD_DUMP[31:24], WORD_DUMP[23:16], WORD_DUMP[15:8],
                 WORD_DUMP[7:0], CH_CR, CH_LF,
                 CH_CR, CH_LF};
    foreach (directed[i]) send_byte(directed[i]);
    wait_results_out();

    for (int phase = 0; phase < 5; phase++) begin
      unique case (phase)
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        3:       begin send_idle_pct = 18; recv_stall_pct = 18; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (phase == 3) send_overflow_run();
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) send_frame(pick_kind());
      wait_results_out();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
